// ===== hw/rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Status codes, register map and control types of the circumcenter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_COLLINEAR = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam logic        REG_COLLINEAR_LIMIT = 1'b0;
  localparam logic [31:0] LIMIT_RESET         = 32'd429;

  typedef struct packed {
    logic valid;
    logic collinear;
  } tcc_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcc_if.sv =====
// ----------------------------------------------------------------------------
// tcc_in_if / tcc_out_if
// Valid/ready channels carrying a triangle request and its circumcenter.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_a_x;
  logic signed [31:0] point_a_y;
  logic signed [31:0] point_b_x;
  logic signed [31:0] point_b_y;
  logic signed [31:0] point_c_x;
  logic signed [31:0] point_c_y;

  modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, input ready);
  modport sink (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                point_c_x, point_c_y, output ready);
endinterface

interface tcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [1:0]         status;

  modport source (output valid, center_x, center_y, status, input ready);
  modport sink (input valid, center_x, center_y, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcc_cfg.sv =====
// ----------------------------------------------------------------------------
// tcc_cfg
// APB register block holding the collinear limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [31:0]      limit
);
  import tcc_pkg::*;

  logic hit;

  assign hit    = (paddr[2] == REG_COLLINEAR_LIMIT);
  assign pready = 1'b1;
  assign prdata = hit ? limit : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && hit) begin
      limit <= pwdata;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Eight-stage datapath: edge vectors, determinant, bisector numerators and
// the signed dividend / divisor pair handed to the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_front #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [31:0]           raw [6],
  input  wire logic [31:0]                  limit,
  output tcc_pkg::tcc_ctl_t                 ctl,
  output logic [3*COORD_BITS+5:0]           mag_x,
  output logic [3*COORD_BITS+5:0]           mag_y,
  output logic                              neg_x,
  output logic                              neg_y,
  output logic [2*COORD_BITS+3:0]           den
);
  import tcc_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int PW  = 2 * C + 2;
  localparam int TW  = 2 * C + 3;
  localparam int LW  = C + 2;
  localparam int LOW = DW + LW + 1;
  localparam int PP  = 3 * C + 4;
  localparam int NX  = 3 * C + 5;
  localparam int NW  = 3 * C + 6;
  localparam int RW  = 2 * C + 4;

  logic signed [C-1:0] c [6];

  genvar g;
  for (g = 0; g < 6; g++) begin : g_coord
    if (C <= 32) begin : g_narrow
      assign c[g] = raw[g][C-1:0];
    end else begin : g_wide
      assign c[g] = {{(C-32){1'b0}}, raw[g]};
    end
  end

  tcc_ctl_t ctl_q [1:8];

  // stage 1
  logic signed [DW-1:0] s1_d0x, s1_d0y, s1_d1x, s1_d1y, s1_ex, s1_ey, s1_sax, s1_say;
  // stage 2
  logic signed [PW-1:0] s2_p [4];
  logic signed [DW-1:0] s2_sax, s2_say, s2_d0x, s2_d0y;
  // stage 3
  logic signed [TW-1:0] s3_det, s3_num;
  logic signed [DW-1:0] s3_sax, s3_say, s3_d0x, s3_d0y;
  // stage 4
  logic signed [DW-1:0] a_op [4];
  logic signed [TW-1:0] b_op [4];
  logic signed [PW-1:0]  s4_hi [4];
  logic signed [LOW-1:0] s4_lo [4];
  logic [TW-1:0]         s4_adet;
  logic                  s4_detneg;
  // stage 5
  logic signed [PP-1:0] s5_p [4];
  logic [TW-1:0]        s5_adet;
  logic                 s5_detneg;
  // stage 6
  logic signed [NX-1:0] s6_nx, s6_ny;
  logic [TW-1:0]        s6_adet;
  logic                 s6_detneg;
  // stage 7
  logic signed [NW-1:0] s7_nx, s7_ny;
  logic [RW-1:0]        s7_den;

  assign a_op[0] = s3_sax;
  assign a_op[1] = s3_d0y;
  assign a_op[2] = s3_say;
  assign a_op[3] = s3_d0x;
  assign b_op[0] = s3_det;
  assign b_op[1] = s3_num;
  assign b_op[2] = s3_det;
  assign b_op[3] = s3_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 8; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[1] <= '{valid: in_valid, collinear: 1'b0};
      ctl_q[2] <= ctl_q[1];
      ctl_q[3] <= ctl_q[2];
      ctl_q[4] <= ctl_q[3];
      ctl_q[5] <= '{valid: ctl_q[4].valid,
                    collinear: (s4_adet == '0) || (s4_adet < TW'(limit))};
      ctl_q[6] <= ctl_q[5];
      ctl_q[7] <= ctl_q[6];
      ctl_q[8] <= ctl_q[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d0x <= DW'(c[0]) - DW'(c[2]);
      s1_d0y <= DW'(c[1]) - DW'(c[3]);
      s1_d1x <= DW'(c[2]) - DW'(c[4]);
      s1_d1y <= DW'(c[3]) - DW'(c[5]);
      s1_ex  <= DW'(c[0]) - DW'(c[4]);
      s1_ey  <= DW'(c[1]) - DW'(c[5]);
      s1_sax <= DW'(c[0]) + DW'(c[2]);
      s1_say <= DW'(c[1]) + DW'(c[3]);

      s2_p[0] <= PW'(s1_d0x) * PW'(s1_d1y);
      s2_p[1] <= PW'(s1_d0y) * PW'(s1_d1x);
      s2_p[2] <= PW'(s1_ex) * PW'(s1_d1x);
      s2_p[3] <= PW'(s1_ey) * PW'(s1_d1y);
      s2_sax  <= s1_sax;
      s2_say  <= s1_say;
      s2_d0x  <= s1_d0x;
      s2_d0y  <= s1_d0y;

      s3_det <= TW'(s2_p[0]) - TW'(s2_p[1]);
      s3_num <= -(TW'(s2_p[2]) + TW'(s2_p[3]));
      s3_sax <= s2_sax;
      s3_say <= s2_say;
      s3_d0x <= s2_d0x;
      s3_d0y <= s2_d0y;

      // split the wide operand so each multiply stays near one word
      for (int i = 0; i < 4; i++) begin
        s4_hi[i] <= PW'(a_op[i]) * PW'($signed(b_op[i][TW-1:LW]));
        s4_lo[i] <= LOW'(a_op[i]) * LOW'($signed({1'b0, b_op[i][LW-1:0]}));
      end
      s4_adet   <= s3_det[TW-1] ? TW'(-s3_det) : TW'(s3_det);
      s4_detneg <= s3_det[TW-1];

      for (int i = 0; i < 4; i++) begin
        s5_p[i] <= (PP'(s4_hi[i]) <<< LW) + PP'(s4_lo[i]);
      end
      s5_adet   <= s4_adet;
      s5_detneg <= s4_detneg;

      s6_nx     <= NX'(s5_p[0]) - NX'(s5_p[1]);
      s6_ny     <= NX'(s5_p[2]) + NX'(s5_p[3]);
      s6_adet   <= s5_adet;
      s6_detneg <= s5_detneg;

      // fold the sign of det into the numerators, add det for rounding
      if (s6_detneg) begin
        s7_nx <= NW'($signed({1'b0, s6_adet})) - NW'(s6_nx);
        s7_ny <= NW'($signed({1'b0, s6_adet})) - NW'(s6_ny);
      end else begin
        s7_nx <= NW'(s6_nx) + NW'($signed({1'b0, s6_adet}));
        s7_ny <= NW'(s6_ny) + NW'($signed({1'b0, s6_adet}));
      end
      s7_den <= {s6_adet, 1'b0};

      neg_x <= s7_nx[NW-1];
      neg_y <= s7_ny[NW-1];
      mag_x <= s7_nx[NW-1] ? NW'(-s7_nx) : NW'(s7_nx);
      mag_y <= s7_ny[NW-1] ? NW'(-s7_ny) : NW'(s7_ny);
      den   <= s7_den;
    end
  end

  assign ctl = ctl_q[8];

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_div.sv =====
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring divider, one quotient bit per stage for both
// coordinates, followed by floor correction, saturation and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire tcc_pkg::tcc_ctl_t            ctl,
  input  wire logic [3*COORD_BITS+5:0]      mag_x,
  input  wire logic [3*COORD_BITS+5:0]      mag_y,
  input  wire logic                         neg_x,
  input  wire logic                         neg_y,
  input  wire logic [2*COORD_BITS+3:0]      den,
  output logic                              out_valid,
  output logic signed [31:0]                center_x,
  output logic signed [31:0]                center_y,
  output logic [1:0]                        status
);
  import tcc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int Q  = C + 1;
  localparam int NW = 3 * C + 6;
  localparam int HW = NW - Q;
  localparam int RW = 2 * C + 4;
  localparam logic [Q:0]   HALF  = (Q+1)'(1) << (C - 1);
  localparam logic [C-1:0] C_MAX = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] C_MIN = {1'b1, {(C-1){1'b0}}};

  tcc_ctl_t      ctl_q [0:Q];
  logic [RW-1:0] den_q [0:Q];
  logic [RW-1:0] rem   [0:Q][2];
  logic [Q-1:0]  quo   [0:Q][2];
  logic          ovf   [0:Q][2];
  logic          neg   [0:Q][2];

  logic [NW-1:0] mag_in [2];
  logic          neg_in [2];
  logic [HW-1:0] hi     [2];

  assign mag_in[0] = mag_x;
  assign mag_in[1] = mag_y;
  assign neg_in[0] = neg_x;
  assign neg_in[1] = neg_y;

  // stage 0: quotients of 2^Q or more only matter as an overflow flag
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hi[l] = mag_in[l][NW-1:Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_q[0] <= den;
      for (int l = 0; l < 2; l++) begin
        ovf[0][l] <= (hi[l] >= HW'(den));
        rem[0][l] <= hi[l][RW-1:0];
        quo[0][l] <= mag_in[l][Q-1:0];
        neg[0][l] <= neg_in[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[0] <= '0;
    end else if (en) begin
      ctl_q[0] <= ctl;
    end
  end

  genvar k;
  for (k = 1; k <= Q; k++) begin : g_step
    logic [RW:0] sh [2];
    logic        ge [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l] = {rem[k-1][l], quo[k-1][l][Q-1]};
        ge[l] = (sh[l] >= {1'b0, den_q[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k] <= '0;
      end else if (en) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= den_q[k-1];
        for (int l = 0; l < 2; l++) begin
          rem[k][l] <= ge[l] ? RW'(sh[l] - {1'b0, den_q[k-1]}) : sh[l][RW-1:0];
          quo[k][l] <= {quo[k-1][l][Q-2:0], ge[l]};
          ovf[k][l] <= ovf[k-1][l];
          neg[k][l] <= neg[k-1][l];
        end
      end
    end
  end

  logic [Q:0]          magq [2];
  logic                sat  [2];
  logic signed [C-1:0] val  [2];
  logic signed [63:0]  ext  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      // floor of a negative quotient rounds the magnitude up
      magq[l] = (Q+1)'(quo[Q][l]) + (Q+1)'(neg[Q][l] && (rem[Q][l] != '0));
      if (neg[Q][l]) begin
        sat[l] = ovf[Q][l] || (magq[l] > HALF);
        val[l] = sat[l] ? C_MIN : C'((Q+1)'(0) - magq[l]);
      end else begin
        sat[l] = ovf[Q][l] || ((Q+1)'(quo[Q][l]) >= HALF);
        val[l] = sat[l] ? C_MAX : C'(quo[Q][l]);
      end
      ext[l] = 64'(val[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_q[Q].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_q[Q].collinear) begin
        center_x <= '0;
        center_y <= '0;
        status   <= STATUS_COLLINEAR;
      end else begin
        center_x <= ext[0][31:0];
        center_y <= ext[1][31:0];
        status   <= (sat[0] || sat[1]) ? STATUS_SATURATED : STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_circumcenter.sv =====
// ----------------------------------------------------------------------------
// triangle_circumcenter
// Circumcenter of three Q16.16 points, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  tri_in    in    valid/ready      point_{a,b,c}_{x,y}, signed Q16.16
//  ctr_out   out   valid/ready      center_x, center_y, status
//  apb       in    psel/penable     collinear_limit at address 0
//
//  One triangle accepted per cycle while the output is not held; the pipe
//  is 8 datapath stages, divider setup, one stage per quotient bit, output.
//  The quotient-bit chain of the divider sets the depth.
//  Reset clears all valid bits and loads collinear_limit with 429.
//  When the output register is full and not taken, the whole pipe holds.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcenter #(
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  tcc_in_if.sink           tri_in,
  tcc_out_if.source        ctr_out
);
  import tcc_pkg::*;

  localparam int C = COORD_BITS;

  logic               en;
  logic               out_valid;
  logic [31:0]        limit;
  logic signed [31:0] raw [6];
  tcc_ctl_t           ctl;
  logic [3*C+5:0]     mag_x, mag_y;
  logic               neg_x, neg_y;
  logic [2*C+3:0]     den;

  assign en           = !out_valid || ctr_out.ready;
  assign tri_in.ready = en;
  assign ctr_out.valid = out_valid;

  assign raw[0] = tri_in.point_a_x;
  assign raw[1] = tri_in.point_a_y;
  assign raw[2] = tri_in.point_b_x;
  assign raw[3] = tri_in.point_b_y;
  assign raw[4] = tri_in.point_c_x;
  assign raw[5] = tri_in.point_c_y;

  tcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  tcc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (tri_in.valid),
    .raw      (raw),
    .limit    (limit),
    .ctl      (ctl),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .neg_x    (neg_x),
    .neg_y    (neg_y),
    .den      (den)
  );

  tcc_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl       (ctl),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .neg_x     (neg_x),
    .neg_y     (neg_y),
    .den       (den),
    .out_valid (out_valid),
    .center_x  (ctr_out.center_x),
    .center_y  (ctr_out.center_y),
    .status    (ctr_out.status)
  );

  a_coll_zero: assert property (@(posedge clk) disable iff (rst)
    ctr_out.valid && ctr_out.status == STATUS_COLLINEAR |->
      ctr_out.center_x == '0 && ctr_out.center_y == '0)
    else $error("collinear result with nonzero center");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    ctr_out.valid |-> ctr_out.status == STATUS_OK ||
      ctr_out.status == STATUS_COLLINEAR || ctr_out.status == STATUS_SATURATED)
    else $error("undefined status code");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !ctr_out.valid)
    else $error("result valid right after reset");

  a_limit_reset: assert property (@(posedge clk)
    rst |=> limit == LIMIT_RESET)
    else $error("collinear limit not restored by reset");

endmodule

`default_nettype wire

// ===== test/tcc_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_tb_pkg
// Request and result types shared by the circumcenter testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_tb_pkg;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } triangle_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [1:0]         status;
  } center_t;

endpackage

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams triangles with random gaps and stalls into triangle_circumcenter,
// predicts each circumcenter and status with wide exact arithmetic, and
// checks the results in order across several collinear_limit settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tcc_pkg::*;
  import tcc_tb_pkg::*;

  localparam int LATENCY = 32 + 11;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tcc_in_if  tri_in ();
  tcc_out_if ctr_out ();

  triangle_circumcenter u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .tri_in(tri_in.sink), .ctr_out(ctr_out.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triangle_t   pending_tris[$];
  center_t     expected_centers[$];
  logic [31:0] limit_reg;
  int          errors = 0;
  int          checked = 0;
  int          n_collinear = 0;
  int          n_saturated = 0;
  bit          calm = 1'b0;
  bit          in_fire = 1'b0;
  int          src_idle = 0;
  int          snk_idle = 0;

  // floor of num/den, den > 0, then clamp to 32 bits
  function automatic logic signed [31:0] round_clamp(logic signed [191:0] num,
                                                     logic signed [191:0] den,
                                                     ref bit sat);
    logic signed [191:0] q;
    logic signed [191:0] r;
    q = num / den;
    r = num % den;
    if (r != 0 && num < 0) q = q - 1;
    if (q > 192'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -192'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic center_t circumcenter(triangle_t t, logic [31:0] limit);
    logic signed [191:0] ax, ay, bx, by, cx, cy;
    logic signed [191:0] d0x, d0y, d1x, d1y, ex, ey, det, mag, num, nx, ny;
    center_t res;
    bit sat;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
    sat = 1'b0;
    d0x = ax - bx; d0y = ay - by;
    d1x = bx - cx; d1y = by - cy;
    ex = ax - cx;  ey = ay - cy;
    det = d0x * d1y - d0y * d1x;
    mag = (det < 0) ? -det : det;
    if (det == 0 || mag < $signed({160'd0, limit})) begin
      res.cx = '0;
      res.cy = '0;
      res.status = STATUS_COLLINEAR;
      return res;
    end
    num = -(ex * d1x + ey * d1y);
    nx = (ax + bx) * det - num * d0y;
    ny = (ay + by) * det + num * d0x;
    if (det < 0) begin
      det = -det;
      nx = -nx;
      ny = -ny;
    end
    res.cx = round_clamp(nx + det, 2 * det, sat);
    res.cy = round_clamp(ny + det, 2 * det, sat);
    res.status = sat ? STATUS_SATURATED : STATUS_OK;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      tri_in.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        expected_centers.push_back(circumcenter(pending_tris.pop_front(), limit_reg));
      end
      // hold the request until it was taken at the last rising edge
      if (!(tri_in.valid && !in_fire)) begin
        if (src_idle > 0) begin
          src_idle = src_idle - 1;
          tri_in.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_idle = $urandom_range(1, 8) - 1;
          tri_in.valid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          tri_in.valid <= 1'b1;
          {tri_in.point_a_x, tri_in.point_a_y, tri_in.point_b_x,
           tri_in.point_b_y, tri_in.point_c_x, tri_in.point_c_y} <= pending_tris[0];
        end else begin
          tri_in.valid <= 1'b0;
        end
      end
      if (snk_idle > 0) begin
        snk_idle = snk_idle - 1;
        ctr_out.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        snk_idle = $urandom_range(1, 8) - 1;
        ctr_out.ready <= 1'b0;
      end else begin
        ctr_out.ready <= 1'b1;
      end
    end
  end

  initial begin
    tri_in.valid = 1'b0;
    {tri_in.point_a_x, tri_in.point_a_y, tri_in.point_b_x,
     tri_in.point_b_y, tri_in.point_c_x, tri_in.point_c_y} = '0;
    ctr_out.ready = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    center_t want;
    in_fire <= !rst && tri_in.valid && tri_in.ready;
    if (!rst && ctr_out.valid && ctr_out.ready) begin
      if (expected_centers.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = expected_centers.pop_front();
        checked++;
        if (want.status == STATUS_COLLINEAR) n_collinear++;
        if (want.status == STATUS_SATURATED) n_saturated++;
        if (ctr_out.center_x !== want.cx) begin
          $error("center_x expected %0d actual %0d", want.cx, ctr_out.center_x);
          errors++;
        end
        if (ctr_out.center_y !== want.cy) begin
          $error("center_y expected %0d actual %0d", want.cy, ctr_out.center_y);
          errors++;
        end
        if (ctr_out.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, ctr_out.status);
          errors++;
        end
      end
    end
  end

  task automatic write_limit(logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_COLLINEAR_LIMIT, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit_reg = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_tris.size() > 0 || tri_in.valid || expected_centers.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
    endcase
  endfunction

  task automatic add_random(int count);
    triangle_t t;
    int mode, kind;
    logic signed [31:0] k;
    repeat (count) begin
      mode = $urandom_range(0, 2);
      t = {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
           rnd_coord(mode), rnd_coord(mode), rnd_coord(mode)};
      kind = $urandom_range(0, 19);
      // make some triangles collinear or nearly so
      if (kind == 0) begin
        k = $signed($urandom_range(0, 6)) - 3;
        t.cx = t.bx + k * (t.bx - t.ax);
        t.cy = t.by + k * (t.by - t.ay);
      end else if (kind == 1) begin
        t.cx = t.bx + (t.bx - t.ax) + $signed($urandom_range(0, 2)) - 1;
        t.cy = t.by + (t.by - t.ay);
      end else if (kind == 2) begin
        t.bx = t.ax;
        t.by = t.ay;
      end
      pending_tris.push_back(t);
    end
  endtask

  initial begin
    triangle_t t;
    limit_reg = LIMIT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, unit triangle, ties, collinear and degenerate cases
    pending_tris.push_back({32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                            32'sh80000000, 32'sh7fffffff, 32'sh80000000});
    pending_tris.push_back({32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                            32'sh80000000, 32'sh80000000, 32'sh80000000});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0, 32'sh10000});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd0, 32'sd3});
    pending_tris.push_back({32'sd0, 32'sd0, -32'sd3, 32'sd0, 32'sd0, -32'sd3});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_tris.push_back({32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd9, 32'sd1});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd10, 32'sd20, 32'sd20});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd0, 32'sd20, 32'sd1});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd100, 32'sd0, 32'sd200, 32'sd5});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sh20000, 32'sd1});
    pending_tris.push_back({32'sh7fffffff, 32'sd0, 32'sh7ffffffe, 32'sd0,
                            32'sh7ffffffd, 32'sd1});
    pending_tris.push_back({32'shffffffff, 32'shffffffff, 32'sh55555555,
                            32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh55555555});
    pending_tris.push_back({-32'sh10000, 32'sd0, 32'sh10000, 32'sd0, 32'sd0, 32'sh10000});
    drain();

    write_limit(32'd0);
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1});
    pending_tris.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd10, 32'sd20, 32'sd20});
    add_random(200);
    drain();

    write_limit(32'hffffffff);
    add_random(250);
    drain();

    write_limit($urandom);
    add_random(250);
    drain();

    write_limit(LIMIT_RESET);
    add_random(300);
    drain();

    calm = 1'b1;
    add_random(150);
    drain();

    $display("checked %0d circumcenters (%0d collinear, %0d saturated) over 5 limits",
             checked, n_collinear, n_saturated);
    if (errors == 0 && expected_centers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
